FILE: src/ctls_pkg.sv
// Shared types, token kind codes and the keyword table of the C-like token scanner.
// Used by every module of the scanner and by its port checker.
package ctls_pkg;

  localparam int CTLS_MAX_TOKEN_LENGTH  = 64;
  localparam int CTLS_KEYWORD_MAX_CHARS = 14;
  localparam int CTLS_FIFO_DEPTH        = 4;   // power of two, at least 2

  localparam int TOKEN_KIND_W = 5;
  localparam int TOKEN_LEN_W  = 7;

  // Token kinds
  localparam logic [TOKEN_KIND_W-1:0] K_KEYWORD  = 5'd0;
  localparam logic [TOKEN_KIND_W-1:0] K_IDENT    = 5'd1;
  localparam logic [TOKEN_KIND_W-1:0] K_INT      = 5'd2;
  localparam logic [TOKEN_KIND_W-1:0] K_FLOAT    = 5'd3;
  localparam logic [TOKEN_KIND_W-1:0] K_STRING   = 5'd4;
  localparam logic [TOKEN_KIND_W-1:0] K_ADD      = 5'd5;
  localparam logic [TOKEN_KIND_W-1:0] K_SUB      = 5'd6;
  localparam logic [TOKEN_KIND_W-1:0] K_DIV      = 5'd7;
  localparam logic [TOKEN_KIND_W-1:0] K_MUL      = 5'd8;
  localparam logic [TOKEN_KIND_W-1:0] K_FLOORDIV = 5'd9;
  localparam logic [TOKEN_KIND_W-1:0] K_MOD      = 5'd10;
  localparam logic [TOKEN_KIND_W-1:0] K_LPAREN   = 5'd11;
  localparam logic [TOKEN_KIND_W-1:0] K_RPAREN   = 5'd12;
  localparam logic [TOKEN_KIND_W-1:0] K_LBRACE   = 5'd13;
  localparam logic [TOKEN_KIND_W-1:0] K_RBRACE   = 5'd14;
  localparam logic [TOKEN_KIND_W-1:0] K_EQUALS   = 5'd15;
  localparam logic [TOKEN_KIND_W-1:0] K_SEMI     = 5'd16;

  // Keyword table: text right-justified, first character in the highest used byte
  localparam int KW_COUNT   = 45;
  localparam int KW_MAX_LEN = 14;
  localparam int KW_LEN_W   = 4;

  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "string", "struct", "switch", "typedef",
    "union", "unsigned", "void", "volatile", "while", "_Alignas",
    "_Alignof", "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary",
    "_Noreturn", {"_Static", "_assert"}, {"_Thread", "_local"}
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd6, 4'd3, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7,
    4'd5, 4'd8, 4'd4, 4'd8, 4'd5, 4'd8,
    4'd8, 4'd7, 4'd5, 4'd8, 4'd8, 4'd10,
    4'd9, 4'd14, 4'd13
  };

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [TOKEN_KIND_W-1:0] token_kind;
    logic [TOKEN_LEN_W-1:0]  token_length;
    logic                    last_of_run;
  } out_word_t;

  // Up to two result words produced by one scanned byte; v1 implies v0
  typedef struct packed {
    logic      v0;
    logic      v1;
    out_word_t w0;
    out_word_t w1;
  } scan_res_t;

endpackage

FILE: src/c_like_token_scanner_unit.sv
// Streaming tokenizer for C-like source text: one byte word in, token words out.
// Depends on ctls_pkg, ctls_scan_core and ctls_token_fifo.
//
// Use:
//   in_word carries one source byte and end_of_text, which marks the final
//   byte of a text and flushes any open token. A word is taken at a clock
//   edge with in_valid high and in_stall low.
//   out_word carries token_kind, token_length and last_of_run; last_of_run
//   marks the last token caused by one input byte. One byte causes zero,
//   one or two tokens.
//   A taken byte is held in a register, scanned when the queue has room for
//   two tokens, and its tokens are written to the queue, from which out_word
//   is read.
//   Throughput: one byte per cycle while in_stall is low; bytes that each
//   cause two tokens slow the flow, since out_word moves one token per cycle.
//   Receiver stall: out_word holds; the queue fills and in_stall rises once
//   fewer than two free slots remain, so nothing is dropped.
//   Reset (rst_n low, synchronous): scanner back to idle, nothing pending,
//   queue empty.
module c_like_token_scanner_unit import ctls_pkg::*; #(
  parameter int MAX_TOKEN_LENGTH  = CTLS_MAX_TOKEN_LENGTH,
  parameter int KEYWORD_MAX_CHARS = CTLS_KEYWORD_MAX_CHARS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  in_word_t  in_word_r;
  logic      in_vld_r, in_vld_nxt;
  logic      room2, advance, in_take;
  scan_res_t scan_res;

  // Advance the held byte into the scanner whenever the queue can absorb two tokens
  assign advance    = in_vld_r && room2;
  assign in_stall   = in_vld_r && !room2;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
  end

  ctls_scan_core #(
    .MAX_TOKEN_LENGTH  (MAX_TOKEN_LENGTH),
    .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .word    (in_word_r),
    .res     (scan_res)
  );

  // Queue the tokens; drop a word from the head when the receiver takes it
  ctls_token_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .push_res  (scan_res),
    .pop       (out_valid && !out_stall),
    .room2     (room2),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

FILE: src/ctls_kw_match.sv
// Parallel keyword compare of the captured word prefix against the keyword table.
// Depends on ctls_pkg for the table.
module ctls_kw_match import ctls_pkg::*; #(
  parameter int KEYWORD_MAX_CHARS = CTLS_KEYWORD_MAX_CHARS,
  parameter int LEN_W             = 7
) (
  input  logic [KEYWORD_MAX_CHARS-1:0][7:0] prefix,
  input  logic [LEN_W-1:0]                  run_len,
  output logic                              is_kw
);

  logic hit;

  always_comb begin
    is_kw = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      hit = (run_len == LEN_W'(KW_LEN[k]));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < int'(KW_LEN[k])) begin
          hit = hit && (prefix[i] == KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - i) +: 8]);
        end
      end
      is_kw = is_kw | hit;
    end
  end

endmodule

FILE: src/ctls_scan_core.sv
// Scanner state (mode, run length, pending symbol, word prefix) and the per-byte
// next-state and token logic. Depends on ctls_pkg and ctls_kw_match.
module ctls_scan_core import ctls_pkg::*; #(
  parameter int MAX_TOKEN_LENGTH  = CTLS_MAX_TOKEN_LENGTH,
  parameter int KEYWORD_MAX_CHARS = CTLS_KEYWORD_MAX_CHARS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  in_word_t  word,
  output scan_res_t res
);

  localparam int LEN_W  = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int KIDX_W = $clog2(KEYWORD_MAX_CHARS);

  localparam logic [2:0] MODE_IDLE   = 3'd0;
  localparam logic [2:0] MODE_IDENT  = 3'd1;
  localparam logic [2:0] MODE_INT    = 3'd2;
  localparam logic [2:0] MODE_FLOAT  = 3'd3;
  localparam logic [2:0] MODE_STRING = 3'd4;

  localparam logic [1:0] PEND_NONE  = 2'd0;
  localparam logic [1:0] PEND_MINUS = 2'd1;
  localparam logic [1:0] PEND_SLASH = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_EQUALS = 8'h3d;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_TOKEN_LENGTH);
  localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);

  logic [2:0]                        mode_r, mode_mid, mode_nxt;
  logic [LEN_W-1:0]                  len_r, len_mid, len_nxt;
  logic [1:0]                        pend_r, pend_mid, pend_nxt;
  logic [KEYWORD_MAX_CHARS-1:0][7:0] prefix_r, prefix_mid;

  logic                    is_let, is_dig, last;
  logic [7:0]              ch;
  logic [2:0]              f_mode;
  logic [LEN_W-1:0]        f_len;
  logic [1:0]              f_pend;
  logic                    f_bvld, f_pf;
  logic [TOKEN_KIND_W-1:0] f_bkind;
  logic                    fresh, pf_we;
  logic [KIDX_W-1:0]       pf_idx;
  logic                    a_vld, b_vld, c_vld, x_vld;
  logic [TOKEN_KIND_W-1:0] a_kind, c_kind, x_kind;
  logic [LEN_W-1:0]        a_len, x_len;
  logic                    kw_a, kw_c;

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] n);
    return (n < LEN_MAX) ? n + LEN_ONE : LEN_MAX;
  endfunction

  // Keyword test for a word closed by this byte, and for a word closed at end of text
  ctls_kw_match #(
    .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS),
    .LEN_W             (LEN_W)
  ) u_kw_close (
    .prefix  (prefix_r),
    .run_len (len_r),
    .is_kw   (kw_a)
  );

  ctls_kw_match #(
    .KEYWORD_MAX_CHARS (KEYWORD_MAX_CHARS),
    .LEN_W             (LEN_W)
  ) u_kw_flush (
    .prefix  (prefix_mid),
    .run_len (len_mid),
    .is_kw   (kw_c)
  );

  always_comb begin
    ch     = word.ch;
    last   = word.end_of_text;
    is_let = ((ch >= 8'h61) && (ch <= 8'h7a)) || ((ch >= 8'h41) && (ch <= 8'h5a)) ||
             (ch == 8'h5f);
    is_dig = (ch >= 8'h30) && (ch <= 8'h39);

    // Byte scanned as the first of a new token
    f_mode  = MODE_IDLE;
    f_len   = '0;
    f_pend  = PEND_NONE;
    f_bvld  = 1'b0;
    f_bkind = K_ADD;
    f_pf    = 1'b0;
    if (is_let) begin
      f_mode = MODE_IDENT;
      f_len  = LEN_ONE;
      f_pf   = 1'b1;
    end else if (is_dig) begin
      f_mode = MODE_INT;
      f_len  = LEN_ONE;
    end else begin
      unique case (ch)
        CH_QUOTE:  f_mode = MODE_STRING;
        CH_MINUS: begin
          if (last) begin
            f_bvld  = 1'b1;
            f_bkind = K_SUB;
          end else begin
            f_pend = PEND_MINUS;
          end
        end
        CH_SLASH: begin
          if (last) begin
            f_bvld  = 1'b1;
            f_bkind = K_DIV;
          end else begin
            f_pend = PEND_SLASH;
          end
        end
        CH_PLUS:   begin f_bvld = 1'b1; f_bkind = K_ADD;    end
        CH_STAR:   begin f_bvld = 1'b1; f_bkind = K_MUL;    end
        CH_MOD:    begin f_bvld = 1'b1; f_bkind = K_MOD;    end
        CH_LPAREN: begin f_bvld = 1'b1; f_bkind = K_LPAREN; end
        CH_RPAREN: begin f_bvld = 1'b1; f_bkind = K_RPAREN; end
        CH_LBRACE: begin f_bvld = 1'b1; f_bkind = K_LBRACE; end
        CH_RBRACE: begin f_bvld = 1'b1; f_bkind = K_RBRACE; end
        CH_EQUALS: begin f_bvld = 1'b1; f_bkind = K_EQUALS; end
        CH_SEMI:   begin f_bvld = 1'b1; f_bkind = K_SEMI;   end
        default: ;
      endcase
    end

    // Continue the open token or resolve the pending symbol
    mode_mid = mode_r;
    len_mid  = len_r;
    pend_mid = PEND_NONE;
    a_vld    = 1'b0;
    a_kind   = K_IDENT;
    a_len    = len_r;
    fresh    = 1'b0;
    pf_we    = 1'b0;
    pf_idx   = '0;

    unique case (pend_r)
      PEND_MINUS: begin
        if (is_dig) begin
          mode_mid = MODE_INT;
          len_mid  = sat_inc(LEN_ONE);
        end else begin
          a_vld  = 1'b1;
          a_kind = K_SUB;
          a_len  = LEN_ONE;
          fresh  = 1'b1;
        end
      end
      PEND_SLASH: begin
        a_vld = 1'b1;
        if (ch == CH_SLASH) begin
          a_kind = K_FLOORDIV;
          a_len  = LEN_TWO;
        end else begin
          a_kind = K_DIV;
          a_len  = LEN_ONE;
          fresh  = 1'b1;
        end
      end
      default: begin
        unique case (mode_r)
          MODE_STRING: begin
            if (ch == CH_QUOTE) begin
              a_vld    = 1'b1;
              a_kind   = K_STRING;
              mode_mid = MODE_IDLE;
              len_mid  = '0;
            end else begin
              len_mid = sat_inc(len_r);
            end
          end
          MODE_IDENT: begin
            if (is_let || is_dig) begin
              if (len_r < LEN_W'(KEYWORD_MAX_CHARS)) begin
                pf_we  = 1'b1;
                pf_idx = len_r[KIDX_W-1:0];
              end
              len_mid = sat_inc(len_r);
            end else begin
              a_vld  = 1'b1;
              a_kind = kw_a ? K_KEYWORD : K_IDENT;
              fresh  = 1'b1;
            end
          end
          MODE_INT: begin
            if (is_dig) begin
              len_mid = sat_inc(len_r);
            end else if (ch == CH_DOT) begin
              mode_mid = MODE_FLOAT;
              len_mid  = sat_inc(len_r);
            end else begin
              a_vld  = 1'b1;
              a_kind = K_INT;
              fresh  = 1'b1;
            end
          end
          MODE_FLOAT: begin
            if (is_dig) begin
              len_mid = sat_inc(len_r);
            end else begin
              a_vld  = 1'b1;
              a_kind = K_FLOAT;
              fresh  = 1'b1;
            end
          end
          default: fresh = 1'b1;
        endcase
      end
    endcase

    if (fresh) begin
      mode_mid = f_mode;
      len_mid  = f_len;
      pend_mid = f_pend;
      if (f_pf) begin
        pf_we  = 1'b1;
        pf_idx = '0;
      end
    end
    b_vld = fresh && f_bvld;

    prefix_mid = prefix_r;
    if (pf_we) begin
      prefix_mid[pf_idx] = ch;
    end

    // Flush the open token on the final byte
    c_vld  = last && (mode_mid != MODE_IDLE);
    c_kind = K_IDENT;
    unique case (mode_mid)
      MODE_IDENT:  c_kind = kw_c ? K_KEYWORD : K_IDENT;
      MODE_INT:    c_kind = K_INT;
      MODE_FLOAT:  c_kind = K_FLOAT;
      MODE_STRING: c_kind = K_STRING;
      default:     c_vld  = 1'b0;
    endcase

    mode_nxt = last ? MODE_IDLE : mode_mid;
    len_nxt  = last ? '0 : len_mid;
    pend_nxt = last ? PEND_NONE : pend_mid;

    // A symbol from the fresh scan and an end-of-text flush never occur together
    x_vld  = b_vld || c_vld;
    x_kind = b_vld ? f_bkind : c_kind;
    x_len  = b_vld ? LEN_ONE : len_mid;

    res.v0 = a_vld || x_vld;
    res.v1 = a_vld && x_vld;
    res.w0.token_kind   = a_vld ? a_kind : x_kind;
    res.w0.token_length = TOKEN_LEN_W'(a_vld ? a_len : x_len);
    res.w0.last_of_run  = !(a_vld && x_vld);
    res.w1.token_kind   = x_kind;
    res.w1.token_length = TOKEN_LEN_W'(x_len);
    res.w1.last_of_run  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= '0;
      pend_r <= PEND_NONE;
    end else if (advance) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prefix_r <= prefix_mid;
    end
  end

endmodule

FILE: src/ctls_token_fifo.sv
// Small result queue: takes up to two words per cycle from the scan core and
// hands one word per cycle to the output channel. Depends on ctls_pkg.
module ctls_token_fifo import ctls_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  scan_res_t push_res,
  input  logic      pop,
  output logic      room2,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int DEPTH = CTLS_FIFO_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_word_t        mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       n_push;

  always_comb begin
    n_push  = push ? ({1'b0, push_res.v0} + {1'b0, push_res.v1}) : 2'd0;
    wp_nxt  = wp_r + PTR_W'(n_push);
    rp_nxt  = rp_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CNT_W'(n_push) - CNT_W'(pop);
  end

  assign room2     = (cnt_r <= CNT_W'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign out_word  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_res.v0) begin
      mem[wp_r] <= push_res.w0;
    end
    if (push && push_res.v1) begin
      mem[wp_r + PTR_W'(1)] <= push_res.w1;
    end
  end

endmodule

FILE: src/ctls_checker.sv
// Port-level checks for the C-like token scanner, attached by bind.
// Depends on ctls_pkg for token kinds.
module ctls_checker import ctls_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("scanner not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  a_run_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.last_of_run |=> out_valid)
    else $error("token run broken before its last word");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.token_kind <= K_SEMI)
    else $error("token kind out of range");

  a_symbol_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.token_kind >= K_ADD) && (out_word.token_kind != K_FLOORDIV)
      |-> out_word.token_length == TOKEN_LEN_W'(1))
    else $error("symbol token with wrong length");

endmodule

bind c_like_token_scanner_unit ctls_checker u_ctls_checker (.*);

FILE: bench/tb_c_like_token_scanner_unit.sv
// Self-checking bench for c_like_token_scanner_unit: streams source bytes in, checks token words out.
// Depends on ctls_pkg for the word types and token kind codes; predicts tokens on its own.
module tb_c_like_token_scanner_unit;
  import ctls_pkg::*;

  localparam int MAX_LEN  = CTLS_MAX_TOKEN_LENGTH;
  localparam int KW_CHARS = CTLS_KEYWORD_MAX_CHARS;
  // Longest quiet stretch of a correct run is the deliberate receiver hold-off;
  // random stalls and sender gaps lengthen quiet stretches as well.
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef enum logic [2:0] {M_IDLE, M_IDENT, M_INT, M_FLOAT, M_STRING} scan_mode_t;
  typedef enum logic [1:0] {P_NONE, P_MINUS, P_SLASH} pend_sym_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  c_like_token_scanner_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // Idle and stall percentages of the current phase, and the hold-off request count
  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mismatches = 0;

  // Predicted scanner state
  scan_mode_t sc_mode;
  logic [6:0] sc_len;
  logic [7:0] sc_prefix [KW_CHARS];
  pend_sym_t  sc_pend;

  out_word_t tok_buf[$];      // tokens of the byte being scanned
  out_word_t tokens_due[$];   // tokens predicted but not yet seen on out_word
  logic [7:0] text_q[$];      // source text about to be sent

  string c_keywords [45] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "inline", "int", "long", "register", "restrict", "return", "short",
    "signed", "sizeof", "static", "string", "struct", "switch", "typedef",
    "union", "unsigned", "void", "volatile", "while", "_Alignas",
    "_Alignof", "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary",
    "_Noreturn", {"_Static", "_assert"}, {"_Thread", "_local"}
  };

  string id_head  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string id_tail  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digits   = "0123456789";
  string op_chars = "+-*/%(){}=;";
  string blanks   = " \t\n";

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [6:0] sat_inc(logic [6:0] n);
    return (n < MAX_LEN) ? n + 7'd1 : 7'(MAX_LEN);
  endfunction

  // At most two tokens can leave one byte; drop anything beyond that.
  function automatic void put_token(logic [TOKEN_KIND_W-1:0] kind, logic [6:0] len);
    out_word_t w;
    if (tok_buf.size() >= 2) return;
    w.token_kind   = kind;
    w.token_length = len;
    w.last_of_run  = 1'b0;
    tok_buf.insert(tok_buf.size(), w);
  endfunction

  // Only prefix entries written for the current word are compared.
  function automatic bit word_is_keyword();
    bit same;
    if (sc_len > KW_CHARS || sc_len >= MAX_LEN) return 1'b0;
    foreach (c_keywords[i]) begin
      if (c_keywords[i].len() == sc_len) begin
        same = 1'b1;
        for (int j = 0; j < sc_len; j++)
          if (c_keywords[i][j] != sc_prefix[j]) same = 1'b0;
        if (same) return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void close_word();
    case (sc_mode)
      M_IDENT:  put_token(word_is_keyword() ? K_KEYWORD : K_IDENT, sc_len);
      M_INT:    put_token(K_INT, sc_len);
      M_FLOAT:  put_token(K_FLOAT, sc_len);
      M_STRING: put_token(K_STRING, sc_len);
      default: ;
    endcase
    sc_mode = M_IDLE;
    sc_len  = '0;
  endfunction

  // Scan a byte as the first byte of a new token.
  function automatic void scan_fresh(logic [7:0] c, logic eot);
    if (is_letter(c)) begin
      sc_mode      = M_IDENT;
      sc_len       = 7'd1;
      sc_prefix[0] = c;
    end else if (is_digit(c)) begin
      sc_mode = M_INT;
      sc_len  = 7'd1;
    end else begin
      case (c)
        "\"": begin
          sc_mode = M_STRING;
          sc_len  = '0;
        end
        "-": if (eot) put_token(K_SUB, 7'd1); else sc_pend = P_MINUS;
        "/": if (eot) put_token(K_DIV, 7'd1); else sc_pend = P_SLASH;
        "+": put_token(K_ADD, 7'd1);
        "*": put_token(K_MUL, 7'd1);
        "%": put_token(K_MOD, 7'd1);
        "(": put_token(K_LPAREN, 7'd1);
        ")": put_token(K_RPAREN, 7'd1);
        "{": put_token(K_LBRACE, 7'd1);
        "}": put_token(K_RBRACE, 7'd1);
        "=": put_token(K_EQUALS, 7'd1);
        ";": put_token(K_SEMI, 7'd1);
        default: ;
      endcase
    end
  endfunction

  // Advance the predicted state by one accepted byte and queue its tokens.
  function automatic void scan_byte(in_word_t w);
    logic [7:0] c;
    logic       eot;
    bit         taken;
    out_word_t  tail;
    c     = w.ch;
    eot   = w.end_of_text;
    taken = 1'b0;
    tok_buf.delete();
    if (sc_pend == P_MINUS) begin
      sc_pend = P_NONE;
      if (is_digit(c)) begin
        sc_mode = M_INT;
        sc_len  = sat_inc(7'd1);
        taken   = 1'b1;
      end else begin
        put_token(K_SUB, 7'd1);
      end
    end else if (sc_pend == P_SLASH) begin
      sc_pend = P_NONE;
      if (c == "/") begin
        put_token(K_FLOORDIV, 7'd2);
        taken = 1'b1;
      end else begin
        put_token(K_DIV, 7'd1);
      end
    end else begin
      case (sc_mode)
        M_STRING: begin
          if (c == "\"") close_word();
          else sc_len = sat_inc(sc_len);
          taken = 1'b1;
        end
        M_IDENT: begin
          if (is_letter(c) || is_digit(c)) begin
            if (sc_len < KW_CHARS) sc_prefix[sc_len] = c;
            sc_len = sat_inc(sc_len);
            taken  = 1'b1;
          end else begin
            close_word();
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            sc_len = sat_inc(sc_len);
            taken  = 1'b1;
          end else if (c == ".") begin
            sc_mode = M_FLOAT;
            sc_len  = sat_inc(sc_len);
            taken   = 1'b1;
          end else begin
            close_word();
          end
        end
        M_FLOAT: begin
          if (is_digit(c)) begin
            sc_len = sat_inc(sc_len);
            taken  = 1'b1;
          end else begin
            close_word();
          end
        end
        default: sc_mode = M_IDLE;
      endcase
    end
    // A byte that ended a token starts the next one
    if (!taken) scan_fresh(c, eot);
    if (eot) begin
      close_word();
      sc_pend = P_NONE;
    end
    if (tok_buf.size() > 0) begin
      tail = tok_buf.pop_back();
      tail.last_of_run = 1'b1;
      tok_buf.insert(tok_buf.size(), tail);
    end
    foreach (tok_buf[i]) tokens_due.insert(tokens_due.size(), tok_buf[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Predict on every accepted byte, check every accepted token word
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(string what, out_word_t want, out_word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected kind %0d len %0d last %0d, got kind %0d len %0d last %0d",
               what, want.token_kind, want.token_length, want.last_of_run,
               got.token_kind, got.token_length, got.last_of_run);
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && in_valid && !in_stall) scan_byte(in_word);
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        note_mismatch("unexpected word", '0, out_word);
      end else begin
        want = tokens_due.pop_front();
        if (want.token_kind   !== out_word.token_kind   ||
            want.token_length !== out_word.token_length ||
            want.last_of_run  !== out_word.last_of_run)
          note_mismatch("token", want, out_word);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long hold-off when a test asks for one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  always @(posedge clk) begin
    int quiet;
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one byte word, after random idle cycles, and hold it until taken.
  // Valid stays high on return so a back-to-back word is not lowered first.
  task automatic send_byte(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{ch: c, end_of_text: eot};
    do @(posedge clk); while (in_stall);
  endtask

  function automatic void add_byte(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] pick(string pool);
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  // Send the queued text; its final byte carries end_of_text.
  task automatic send_queue();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_text(string s);
    text_q.delete();
    push_str(s);
    send_queue();
  endtask

  // Append one random token; mostly well formed, with noise and near misses.
  function automatic void add_token(bit final_tok);
    int n;
    int kind;
    logic [7:0] c;
    kind = $urandom_range(11);
    case (kind)
      0, 10: push_str(c_keywords[$urandom_range(44)]);
      1, 2: begin
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 10);
        add_byte(pick(id_head));
        repeat (n - 1) add_byte(pick(id_tail));
      end
      3, 4: begin
        if ($urandom_range(2) == 0) add_byte("-");
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 6);
        repeat (n) add_byte(pick(digits));
        if (kind == 4) begin
          add_byte(".");
          repeat ($urandom_range(4)) add_byte(pick(digits));
          if ($urandom_range(3) == 0) add_byte(".");
        end
      end
      5: begin
        add_byte("\"");
        n = ($urandom_range(19) == 0) ? $urandom_range(60, 80) : $urandom_range(8);
        repeat (n) begin
          c = 8'($urandom_range(255));
          if (c == "\"") c = "q";
          add_byte(c);
        end
        // leave the last string of a text open now and then
        if (!(final_tok && $urandom_range(3) == 0)) add_byte("\"");
      end
      6, 7: add_byte(pick(op_chars));
      8: push_str("//");
      9: add_byte(8'($urandom_range(255)));
      default: begin
        // keyword with a trailing character: must come out as an identifier
        push_str(c_keywords[$urandom_range(44)]);
        add_byte(pick(id_tail));
      end
    endcase
    if ($urandom_range(9) < 6) add_byte(pick(blanks));
  endfunction

  task automatic run_random(int n_items);
    int sent;
    int n_tok;
    sent = 0;
    while (sent < n_items) begin
      text_q.delete();
      n_tok = $urandom_range(3, 10);
      for (int i = 0; i < n_tok; i++) add_token(i == n_tok - 1);
      send_queue();
      sent += text_q.size();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_tokens();
    idle_pct  = 0;
    stall_pct <= 0;
    // keyword, minus before a digit, trailing dot, ';' ends the float
    send_text("if-7.;");
    // floor division, then '/' on the final byte after a word
    send_text("//x/");
    // string left open at end of text
    send_text("\"ab");
    // second dot drops, minus on the final byte
    send_text("1..-");
    // the single-character operators +, *, % and =, and every bracket
    send_text("+*%(){}=");
    // byte extremes, both dropped
    text_q.delete();
    add_byte(8'h00);
    add_byte(8'hFF);
    send_queue();
  endtask

  task automatic test_random_no_idle();
    idle_pct  = 0;
    stall_pct <= 0;
    run_random(105);
  endtask

  task automatic test_random_sender_idle();
    idle_pct  = 51;
    stall_pct <= 0;
    run_random(105);
  endtask

  task automatic test_random_receiver_stall();
    idle_pct  = 0;
    stall_pct <= 51;
    run_random(105);
  endtask

  task automatic test_random_both_idle();
    idle_pct  = 21;
    stall_pct <= 21;
    run_random(105);
  endtask

  // Hold the receiver off while bytes keep coming so the queue fills
  // and in_stall has to rise.
  task automatic test_pressure_hold_off();
    idle_pct  = 0;
    stall_pct <= 0;
    hold_seq  <= hold_seq + 1;
    run_random(100);
  endtask

  initial begin
    sc_mode = M_IDLE;
    sc_len  = '0;
    sc_pend = P_NONE;
    foreach (sc_prefix[i]) sc_prefix[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_tokens();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_pressure_hold_off();

    // Drop valid, drain what is still due, then watch for stray words
    in_valid <= 1'b0;
    stall_pct <= 0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0 && tokens_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
